// ===== hdl/cgdf_pkg.sv =====
// Shared types and constants for the colour grid duplicate filter.
// Used by cgdf_ctrl, cgdf_datapath and colour_grid_duplicate_filter.
package cgdf_pkg;

  localparam int DEF_MAX_GRID = 64;
  localparam int COMP_W       = 17;   // colour component, 65536 = 1.0
  localparam int FRAC_W       = 16;   // fraction bits of a component
  localparam int GRID_W       = 7;    // grid_size register
  localparam int CELL_OUT_W   = 18;   // cell_number field

  localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(32);

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic              command;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [COMP_W-1:0]     out_red;
    logic [COMP_W-1:0]     out_green;
    logic [COMP_W-1:0]     out_blue;
    logic [CELL_OUT_W-1:0] cell_number;
  } pix_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load_pix;
    logic scale;
    logic mix;
    logic lin;
    logic read;
    logic clr_write;
    logic mark_write;
    logic out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mark_hit;
    logic out_free;
    logic clr_last;
  } dp_sts_t;

endpackage

// ===== hdl/cgdf_ctrl.sv =====
// Sequencing state machine of the colour grid duplicate filter.
// Depends on cgdf_pkg for the command and status structs.
module cgdf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_command,
  output logic             in_stall,
  output cgdf_pkg::dp_cmd_t cmd,
  input  cgdf_pkg::dp_sts_t sts
);
  import cgdf_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCALE,
    ST_MIX,
    ST_LIN,
    ST_READ,
    ST_CHECK
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_pix = 1'b1;
          state_nxt    = (in_command == CMD_CLEAR) ? ST_CLEAR : ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        cmd.mix   = 1'b1;
        state_nxt = ST_LIN;
      end
      ST_LIN: begin
        cmd.lin   = 1'b1;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        // drop a repeat; otherwise hold until the output register frees up
        priority if (sts.mark_hit) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.mark_write = 1'b1;
          cmd.out_load   = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      in_stall_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != ST_IDLE);
    end
  end

  assign in_stall = in_stall_r;

endmodule

// ===== hdl/cgdf_datapath.sv =====
// Datapath of the colour grid duplicate filter: scaling, cell numbering,
// visited bitmap memory, clear sweep and output register. Uses cgdf_pkg.
module cgdf_datapath #(
  parameter int MAX_GRID = cgdf_pkg::DEF_MAX_GRID
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cgdf_pkg::dp_cmd_t           cmd,
  output cgdf_pkg::dp_sts_t           sts,
  input  cgdf_pkg::pix_in_t           in_data,
  input  logic                        cfg_wr_en,
  input  logic [cgdf_pkg::GRID_W-1:0] cfg_wr_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output cgdf_pkg::pix_out_t          out_data
);
  import cgdf_pkg::*;

  localparam int G_W     = $clog2(MAX_GRID + 1);
  localparam int X_W     = $clog2(MAX_GRID);
  localparam int T_W     = 2 * X_W;
  localparam int A_W     = 3 * X_W;
  localparam int ROW_LOG = (A_W > 6) ? 6 : A_W - 1;
  localparam int ROW_W   = 1 << ROW_LOG;
  localparam int RA_W    = A_W - ROW_LOG;
  localparam int ROWS    = 1 << RA_W;
  localparam int CMP_W   = (G_W > GRID_W) ? G_W : GRID_W;
  localparam int P_W     = COMP_W + G_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_GRID);

  function automatic logic [X_W-1:0] cell_of(input logic [COMP_W-1:0] c,
                                             input logic [G_W-1:0]    g);
    logic [P_W-1:0] prod;
    logic [G_W:0]   q;
    prod = P_W'(c) * P_W'(g);
    q    = prod[P_W-1:FRAC_W];
    if (q >= {1'b0, g}) q = {1'b0, g} - (G_W + 1)'(1);
    return X_W'(q);
  endfunction

  logic [GRID_W-1:0] grid_r;
  logic [CMP_W-1:0]  g_cmp;
  logic [G_W-1:0]    g_eff;
  logic [G_W-1:0]    g_r;
  pix_in_t           pix_r;
  logic [X_W-1:0]    x_r, y_r, z_r;
  logic [T_W-1:0]    t_r;
  logic [A_W-1:0]    idx_r;
  logic [ROW_W-1:0]  marks_r [ROWS];
  logic [ROW_W-1:0]  rd_row_r;
  logic [RA_W-1:0]   clr_pos_r;
  logic              out_valid_r;
  pix_out_t          out_data_r;

  logic [RA_W-1:0]    row_sel;
  logic [ROW_LOG-1:0] bit_sel;
  logic               out_free;

  assign row_sel = idx_r[A_W-1:ROW_LOG];
  assign bit_sel = idx_r[ROW_LOG-1:0];

  // saturate grid size into 1..MAX_GRID
  always_comb begin
    g_cmp = CMP_W'(grid_r);
    priority if (g_cmp == '0)    g_cmp = CMP_W'(1);
    else if (g_cmp > MAX_CMP)    g_cmp = MAX_CMP;
    else                         g_cmp = CMP_W'(grid_r);
  end
  assign g_eff = G_W'(g_cmp);

  always_ff @(posedge clk) begin
    if (!rst_n) grid_r <= GRID_RESET;
    else if (cfg_wr_en) grid_r <= cfg_wr_data;
  end

  // index pipeline, one step per command
  always_ff @(posedge clk) begin
    if (cmd.load_pix) begin
      pix_r <= in_data;
      g_r   <= g_eff;
    end
    if (cmd.scale) begin
      x_r <= cell_of(pix_r.red,   g_r);
      y_r <= cell_of(pix_r.green, g_r);
      z_r <= cell_of(pix_r.blue,  g_r);
    end
    if (cmd.mix) t_r <= T_W'(z_r) * T_W'(g_r) + T_W'(y_r);
    if (cmd.lin) idx_r <= A_W'(t_r) * A_W'(g_r) + A_W'(x_r);
  end

  // visited bitmap, one row per address
  always_ff @(posedge clk) begin
    if (cmd.read) rd_row_r <= marks_r[row_sel];
    if (cmd.clr_write) begin
      marks_r[clr_pos_r] <= '0;
    end else if (cmd.mark_write) begin
      marks_r[row_sel] <= rd_row_r | (ROW_W'(1) << bit_sel);
    end
  end

  // sweep position wraps back to zero after the last row
  always_ff @(posedge clk) begin
    if (!rst_n) clr_pos_r <= '0;
    else if (cmd.clr_write) clr_pos_r <= clr_pos_r + RA_W'(1);
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.out_red     <= pix_r.red;
      out_data_r.out_green   <= pix_r.green;
      out_data_r.out_blue    <= pix_r.blue;
      out_data_r.cell_number <= CELL_OUT_W'(idx_r);
    end
  end

  assign sts.mark_hit = rd_row_r[bit_sel];
  assign sts.out_free = out_free;
  assign sts.clr_last = (clr_pos_r == '1);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/colour_grid_duplicate_filter.sv =====
// Colour grid duplicate filter: passes the first pixel seen in each colour
// grid cell and drops repeats. Input beats carry a pixel or a clear command.
// Input beats are taken on in_valid with in_stall low; result beats leave on
// out_valid and are taken when out_stall is low. grid_size is written with
// cfg_wr_en/cfg_wr_data and is sampled when a pixel beat is taken.
// A pixel beat passes a scaling step (three scaling multipliers), two
// multiply-add steps for the cell number, a registered bitmap read and a
// check/write step before the next input beat can be taken. For a kept
// pixel out_valid rises after the check/write step; a repeat produces no
// beat. The bitmap is one memory of 64-bit rows when 3*clog2(MAX_GRID) > 6,
// 2^(3*clog2(MAX_GRID)-6) rows, 4096 at the default MAX_GRID of 64. After
// reset, and after each clear command, in_stall stays high while a sweep
// zeroes one row per cycle. A result waiting on out_stall does not block
// the next input beat; only the check step of a later kept pixel waits for
// the output register to drain.
module colour_grid_duplicate_filter #(
  parameter int MAX_GRID = cgdf_pkg::DEF_MAX_GRID
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  cgdf_pkg::pix_in_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output cgdf_pkg::pix_out_t          out_data,
  input  logic                        cfg_wr_en,
  input  logic [cgdf_pkg::GRID_W-1:0] cfg_wr_data
);
  import cgdf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  cgdf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .sts        (sts)
  );

  cgdf_datapath #(
    .MAX_GRID (MAX_GRID)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  // reset starts the clearing sweep, so no beat is taken right after it
  a_reset_stalls: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  // one beat at a time: busy the cycle after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous beat in flight");

  // a result is loaded only for an unmarked cell into a free output register
  a_load_new_cell: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.mark_hit && sts.out_free && cmd.mark_write)
    else $error("result loaded for marked cell or busy output");

  // the clearing sweep and a mark update never share the write port
  a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_write && (cmd.mark_write || cmd.read || cmd.load_pix)))
    else $error("bitmap sweep overlaps pixel work");

endmodule
